FILE: hw/rtl/mwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types, codes and constants for the maze wall-follow navigator.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int RANGE_W = 16;
  localparam int TIME_W  = 32;
  localparam int PCT_W   = 7;
  localparam int TURN_W  = 12;
  localparam int CNT_W   = 8;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 32;
  localparam int LANES   = 6;

  // Fixed navigation constants
  localparam int FRONT_CRITICAL_MM      = 150;
  localparam int SIDE_CONTACT_MM        = 80;
  localparam int CONTACT_DEBOUNCE_MS    = 500;
  localparam int AVOID_TURN_TENTHS      = 450;
  localparam int WALL_CORRECTION_TENTHS = 100;
  localparam int PCT_MAX                = 100;

  localparam logic signed [TURN_W-1:0] TURN_AVOID_LEFT  = TURN_W'(-AVOID_TURN_TENTHS);
  localparam logic signed [TURN_W-1:0] TURN_AVOID_RIGHT = TURN_W'(AVOID_TURN_TENTHS);
  localparam logic signed [TURN_W-1:0] TURN_WALL_LEFT   = TURN_W'(-WALL_CORRECTION_TENTHS);
  localparam logic signed [TURN_W-1:0] TURN_WALL_RIGHT  = TURN_W'(WALL_CORRECTION_TENTHS);
  localparam logic signed [TURN_W-1:0] TURN_WALL_HALF   = TURN_W'(WALL_CORRECTION_TENTHS / 2);
  localparam logic signed [TURN_W-1:0] TURN_NONE        = '0;

  // Item kinds
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STOP   = 2'd2;

  // Navigation modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WALL   = 2'd1;
  localparam logic [1:0] MODE_AVOID  = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FRONT_AVOID   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WALL_TARGET   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WALL_TOL      = 3'd2;
  localparam logic [IDX_W-1:0] REG_REAR_RETURN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RETURN_COUNT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_RUN       = 3'd5;
  localparam logic [IDX_W-1:0] REG_CRUISE_SPEED  = 3'd6;
  localparam logic [IDX_W-1:0] REG_AVOID_SPEED   = 3'd7;

  // Lane order
  localparam int LN_FRONT  = 0;
  localparam int LN_FLEFT  = 1;
  localparam int LN_FRIGHT = 2;
  localparam int LN_LEFT   = 3;
  localparam int LN_RIGHT  = 4;
  localparam int LN_REAR   = 5;

  typedef struct packed {
    logic [1:0]         func;
    logic [TIME_W-1:0]  time_ms;
    logic [RANGE_W-1:0] front_mm;
    logic [RANGE_W-1:0] front_left_mm;
    logic [RANGE_W-1:0] front_right_mm;
    logic [RANGE_W-1:0] left_mm;
    logic [RANGE_W-1:0] right_mm;
    logic [RANGE_W-1:0] rear_mm;
  } mwf_in_t;

  typedef struct packed {
    logic                     running;
    logic [1:0]               mode;
    logic                     stop_all;
    logic                     drive_valid;
    logic [PCT_W-1:0]         speed_pct;
    logic signed [TURN_W-1:0] turn_tenths;
    logic [RANGE_W-1:0]       contact_count;
    logic                     circuit_done;
  } mwf_out_t;

  typedef struct packed {
    logic [RANGE_W-1:0] front_avoid_mm;
    logic [RANGE_W-1:0] wall_target_mm;
    logic [RANGE_W-1:0] wall_tolerance_mm;
    logic [RANGE_W-1:0] rear_return_mm;
    logic [CNT_W-1:0]   return_confirm_count;
    logic [TIME_W-1:0]  min_run_ms;
    logic [PCT_W-1:0]   cruise_speed_pct;
    logic [PCT_W-1:0]   avoid_speed_pct;
  } mwf_cfg_t;

  // Per-reading findings of one lane
  typedef struct packed {
    logic present;  // reading is non-zero
    logic le_hit;   // present and at or below the contact limit
    logic lt_hit;   // present and below the proximity limit
  } mwf_lane_t;

endpackage

FILE: hw/rtl/mwf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_lane
// One range-reading lane: presence, contact and proximity tests.
// ----------------------------------------------------------------------------
module mwf_lane import mwf_pkg::*; (
  input  logic [RANGE_W-1:0] reading,
  input  logic [RANGE_W-1:0] le_lim,
  input  logic [RANGE_W-1:0] lt_lim,
  output mwf_lane_t          res
);

  // Compare the reading against both limits; zero means no reading
  always_comb begin
    res.present = (reading != '0);
    res.le_hit  = res.present && (reading <= le_lim);
    res.lt_hit  = res.present && (reading < lt_lim);
  end

endmodule

FILE: hw/rtl/mwf_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_merge
// Run state and merge of lane findings into one navigation decision per word.
// ----------------------------------------------------------------------------
module mwf_merge import mwf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mwf_in_t               in_word,
  input  mwf_cfg_t              cfg,
  input  mwf_lane_t [LANES-1:0] lanes,
  output mwf_out_t              res
);

  logic               run_active_r, run_active_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               finished_r, finished_nxt;
  logic [RANGE_W-1:0] contacts_r, contacts_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic [TIME_W-1:0]  run_start_r, run_start_nxt;
  logic [TIME_W-1:0]  last_contact_r, last_contact_nxt;

  logic               contact_hit, debounce_ok, run_long, rear_hit, done;
  logic               avoid_hit, left_room_ge, left_near;
  logic [TIME_W-1:0]  since_contact, since_start;
  logic [CNT_W-1:0]   seen_upd, need;
  logic [RANGE_W:0]   left_ref, right_ref;
  logic [RANGE_W:0]   rt_diff_mag;
  logic [RANGE_W+1:0] left_x2, target_x3;
  logic [PCT_W-1:0]   cruise_pct, avoid_pct;
  logic               stop_all, drive;
  logic [PCT_W-1:0]   speed;
  logic signed [TURN_W-1:0] turn;

  // Shared tests on the current word
  always_comb begin
    contact_hit   = lanes[LN_FRONT].le_hit || lanes[LN_LEFT].le_hit || lanes[LN_RIGHT].le_hit;
    since_contact = in_word.time_ms - last_contact_r;
    debounce_ok   = since_contact >= TIME_W'(CONTACT_DEBOUNCE_MS);
    since_start   = in_word.time_ms - run_start_r;
    run_long      = since_start >= cfg.min_run_ms;
    rear_hit      = run_long && lanes[LN_REAR].lt_hit;
    if (!rear_hit) begin
      seen_upd = '0;
    end else if (seen_r == '1) begin
      seen_upd = seen_r;
    end else begin
      seen_upd = seen_r + 1'b1;
    end
    need      = (cfg.return_confirm_count == '0) ? CNT_W'(1) : cfg.return_confirm_count;
    done      = seen_upd >= need;
    avoid_hit = lanes[LN_FRONT].lt_hit || lanes[LN_FLEFT].lt_hit || lanes[LN_FRIGHT].lt_hit;

    // Room on each side: side reading, else diagonal, else beyond any reading
    if (lanes[LN_LEFT].present) begin
      left_ref = {1'b0, in_word.left_mm};
    end else if (lanes[LN_FLEFT].present) begin
      left_ref = {1'b0, in_word.front_left_mm};
    end else begin
      left_ref = {1'b1, {RANGE_W{1'b0}}};
    end
    if (lanes[LN_RIGHT].present) begin
      right_ref = {1'b0, in_word.right_mm};
    end else if (lanes[LN_FRIGHT].present) begin
      right_ref = {1'b0, in_word.front_right_mm};
    end else begin
      right_ref = {1'b1, {RANGE_W{1'b0}}};
    end
    left_room_ge = left_ref >= right_ref;

    // Exact 1.5x test: 2*left < 3*target
    left_x2   = {1'b0, in_word.left_mm, 1'b0};
    target_x3 = {1'b0, cfg.wall_target_mm, 1'b0} + {2'b00, cfg.wall_target_mm};
    left_near = lanes[LN_LEFT].present && (left_x2 < target_x3);

    // Distance from target, absolute
    if (cfg.wall_target_mm >= in_word.right_mm) begin
      rt_diff_mag = {1'b0, cfg.wall_target_mm} - {1'b0, in_word.right_mm};
    end else begin
      rt_diff_mag = {1'b0, in_word.right_mm} - {1'b0, cfg.wall_target_mm};
    end

    cruise_pct = (cfg.cruise_speed_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                          : cfg.cruise_speed_pct;
    avoid_pct  = (cfg.avoid_speed_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                         : cfg.avoid_speed_pct;
  end

  // Next state and the result word
  always_comb begin
    run_active_nxt   = run_active_r;
    mode_nxt         = mode_r;
    finished_nxt     = finished_r;
    contacts_nxt     = contacts_r;
    seen_nxt         = seen_r;
    run_start_nxt    = run_start_r;
    last_contact_nxt = last_contact_r;
    stop_all         = 1'b0;
    drive            = 1'b0;
    speed            = '0;
    turn             = TURN_NONE;
    priority if (in_word.func == FUNC_START) begin
      run_active_nxt   = 1'b1;
      finished_nxt     = 1'b0;
      contacts_nxt     = '0;
      seen_nxt         = '0;
      mode_nxt         = MODE_WALL;
      run_start_nxt    = in_word.time_ms;
      last_contact_nxt = in_word.time_ms - TIME_W'(CONTACT_DEBOUNCE_MS);
    end else if (in_word.func == FUNC_STOP) begin
      run_active_nxt = 1'b0;
      if (!finished_r) begin
        mode_nxt = MODE_IDLE;
      end
    end else if (in_word.func == FUNC_UPDATE && run_active_r) begin
      if (contact_hit && debounce_ok) begin
        if (contacts_r != '1) begin
          contacts_nxt = contacts_r + 1'b1;
        end
        last_contact_nxt = in_word.time_ms;
      end
      seen_nxt = seen_upd;
      priority if (done) begin
        finished_nxt   = 1'b1;
        mode_nxt       = MODE_FINISH;
        run_active_nxt = 1'b0;
        stop_all       = 1'b1;
      end else if (avoid_hit) begin
        mode_nxt = MODE_AVOID;
        drive    = 1'b1;
        speed    = avoid_pct;
        turn     = left_room_ge ? TURN_AVOID_LEFT : TURN_AVOID_RIGHT;
      end else begin
        mode_nxt = MODE_WALL;
        drive    = 1'b1;
        speed    = cruise_pct;
        priority if (!lanes[LN_RIGHT].present) begin
          turn = left_near ? TURN_WALL_RIGHT : TURN_WALL_HALF;
        end else if (rt_diff_mag <= {1'b0, cfg.wall_tolerance_mm}) begin
          turn = TURN_NONE;
        end else if (cfg.wall_target_mm > in_word.right_mm) begin
          turn = TURN_WALL_LEFT;
        end else begin
          turn = TURN_WALL_RIGHT;
        end
      end
    end else begin
      // hold the run state: unused code or an update while stopped
    end

    res.running       = run_active_nxt;
    res.mode          = mode_nxt;
    res.stop_all      = stop_all;
    res.drive_valid   = drive;
    res.speed_pct     = speed;
    res.turn_tenths   = turn;
    res.contact_count = contacts_nxt;
    res.circuit_done  = finished_nxt;
  end

  // Advance the run state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r   <= 1'b0;
      mode_r         <= MODE_IDLE;
      finished_r     <= 1'b0;
      contacts_r     <= '0;
      seen_r         <= '0;
      run_start_r    <= '0;
      last_contact_r <= '0;
    end else if (push) begin
      run_active_r   <= run_active_nxt;
      mode_r         <= mode_nxt;
      finished_r     <= finished_nxt;
      contacts_r     <= contacts_nxt;
      seen_r         <= seen_nxt;
      run_start_r    <= run_start_nxt;
      last_contact_r <= last_contact_nxt;
    end
  end

  // A finished circuit leaves the run stopped in finish mode
  a_finish_mode: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (mode_r == MODE_FINISH && !run_active_r))
    else $error("finished flag without finish mode");

  // An active run is always wall following or avoiding
  a_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
    run_active_r |-> (mode_r == MODE_WALL || mode_r == MODE_AVOID))
    else $error("active run in wrong mode");

  // Without a run or a finish the mode is idle
  a_idle_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_active_r && !finished_r) |-> (mode_r == MODE_IDLE))
    else $error("stopped navigator not idle");

endmodule

FILE: hw/rtl/maze_wall_follow_navigator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_wall_follow_navigator_top
// Wall-following maze navigator: six range lanes, a merge stage holding the
// run state, and a two-entry output buffer.
//
//   Channel  Signals                       Direction  Moves
//   in_      in_valid/in_ready/in_data     input      one command word
//   out_     out_valid/out_ready/out_data  output     one result word
//   cfg_     cfg_we/cfg_index/cfg_wdata    input      one register write
//
// One word is accepted per cycle while in_ready is high; its result is
// registered in an output entry. The lane compares and the merge stage
// decide in the accept cycle, so the run state feeds the next word with no
// bubble. Reset is synchronous and restores register defaults and an idle
// navigator. A stalled output keeps one further word in the skid entry;
// in_ready drops only while both output entries are full.
// ----------------------------------------------------------------------------
module maze_wall_follow_navigator_top import mwf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mwf_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mwf_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  mwf_cfg_t              cfg_r;
  mwf_lane_t [LANES-1:0] lanes;
  mwf_out_t              res;
  mwf_out_t              out_r, skid_r;
  logic                  out_valid_r, skid_valid_r;
  logic                  push, pop;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_avoid_mm       <= RANGE_W'(300);
      cfg_r.wall_target_mm       <= RANGE_W'(250);
      cfg_r.wall_tolerance_mm    <= RANGE_W'(50);
      cfg_r.rear_return_mm       <= RANGE_W'(400);
      cfg_r.return_confirm_count <= CNT_W'(3);
      cfg_r.min_run_ms           <= TIME_W'(20000);
      cfg_r.cruise_speed_pct     <= PCT_W'(50);
      cfg_r.avoid_speed_pct      <= PCT_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRONT_AVOID:  cfg_r.front_avoid_mm       <= cfg_wdata[RANGE_W-1:0];
        REG_WALL_TARGET:  cfg_r.wall_target_mm       <= cfg_wdata[RANGE_W-1:0];
        REG_WALL_TOL:     cfg_r.wall_tolerance_mm    <= cfg_wdata[RANGE_W-1:0];
        REG_REAR_RETURN:  cfg_r.rear_return_mm       <= cfg_wdata[RANGE_W-1:0];
        REG_RETURN_COUNT: cfg_r.return_confirm_count <= cfg_wdata[CNT_W-1:0];
        REG_MIN_RUN:      cfg_r.min_run_ms           <= cfg_wdata[TIME_W-1:0];
        REG_CRUISE_SPEED: cfg_r.cruise_speed_pct     <= cfg_wdata[PCT_W-1:0];
        REG_AVOID_SPEED:  cfg_r.avoid_speed_pct      <= cfg_wdata[PCT_W-1:0];
      endcase
    end
  end

  // Range lanes
  mwf_lane u_lane_front (
    .reading (in_data.front_mm),
    .le_lim  (RANGE_W'(FRONT_CRITICAL_MM)),
    .lt_lim  (cfg_r.front_avoid_mm),
    .res     (lanes[LN_FRONT])
  );

  mwf_lane u_lane_fleft (
    .reading (in_data.front_left_mm),
    .le_lim  (RANGE_W'(0)),
    .lt_lim  (cfg_r.front_avoid_mm),
    .res     (lanes[LN_FLEFT])
  );

  mwf_lane u_lane_fright (
    .reading (in_data.front_right_mm),
    .le_lim  (RANGE_W'(0)),
    .lt_lim  (cfg_r.front_avoid_mm),
    .res     (lanes[LN_FRIGHT])
  );

  mwf_lane u_lane_left (
    .reading (in_data.left_mm),
    .le_lim  (RANGE_W'(SIDE_CONTACT_MM)),
    .lt_lim  (RANGE_W'(0)),
    .res     (lanes[LN_LEFT])
  );

  mwf_lane u_lane_right (
    .reading (in_data.right_mm),
    .le_lim  (RANGE_W'(SIDE_CONTACT_MM)),
    .lt_lim  (RANGE_W'(0)),
    .res     (lanes[LN_RIGHT])
  );

  mwf_lane u_lane_rear (
    .reading (in_data.rear_mm),
    .le_lim  (RANGE_W'(0)),
    .lt_lim  (cfg_r.rear_return_mm),
    .res     (lanes[LN_REAR])
  );

  // Merge stage and run state
  mwf_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_data),
    .cfg     (cfg_r),
    .lanes   (lanes),
    .res     (res)
  );

  // Handshakes
  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Two-entry output buffer: refill the head from skid first, else from the merge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  // The skid entry is only used behind a full head
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without head word");

  // A drive command only comes from a running navigator
  a_drive_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.drive_valid) |-> (out_r.running && !out_r.stop_all))
    else $error("drive command outside a run");

  // Stop-all always reports a completed circuit
  a_stop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.stop_all) |-> (out_r.circuit_done && out_r.mode == MODE_FINISH))
    else $error("stop-all without finished circuit");

endmodule
